FILE: rtl/mwo_pkg.sv
// shared constants, codes and the arctangent table of the mecanum odometry block
`default_nettype none

package mwo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int SUM_WIDTH    = 24;
    localparam int GAIN_W       = 24;
    localparam int DV_W         = SUM_WIDTH + GAIN_W;
    localparam int MUL_W        = (SUM_WIDTH > 32) ? SUM_WIDTH : 32;
    localparam int POS_W        = 48;
    localparam int ACC_W        = ((DV_W > POS_W) ? DV_W : POS_W) + 3;
    localparam int CW           = 34;
    localparam int CI_W         = $clog2(CORDIC_STEPS);

    localparam logic [GAIN_W-1:0] LIN_GAIN_RST = 24'd360000;
    localparam logic [GAIN_W-1:0] ANG_GAIN_RST = 24'd286000;
    localparam logic [31:0]       MAX_GAP_RST  = 32'd500000;

    localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;
    localparam logic signed [31:0]   QUARTER      = 32'sh4000_0000;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_INIT   = 2'd1,
        CMD_ZERO   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_LIN_GAIN = 2'd0,
        REG_ANG_GAIN = 2'd1,
        REG_MAX_GAP  = 2'd2,
        REG_NONE     = 2'd3
    } reg_idx_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            5'd24:   v = 32'h0000_0029;
            5'd25:   v = 32'h0000_0014;
            5'd26:   v = 32'h0000_000A;
            5'd27:   v = 32'h0000_0005;
            5'd28:   v = 32'h0000_0003;
            5'd29:   v = 32'h0000_0001;
            5'd30:   v = 32'h0000_0001;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    // clip an exact wheel sum to the signed sum width
    function automatic logic signed [SUM_WIDTH-1:0] sat_sum(input logic signed [33:0] v);
        logic signed [34:0] smax;
        logic signed [34:0] smin;
        logic signed [34:0] w;
        logic signed [SUM_WIDTH-1:0] r;
        smax = (35'sd1 <<< (SUM_WIDTH - 1)) - 35'sd1;
        smin = -smax - 35'sd1;
        w = 35'(v);
        if (w > smax) begin
            r = SUM_WIDTH'(smax);
        end else if (w < smin) begin
            r = SUM_WIDTH'(smin);
        end else begin
            r = SUM_WIDTH'(w);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mecanum_wheel_odometry_top.sv
// mecanum odometry: sequencer, shared multiplier and iterative cordic
// an update runs decode, the wheel sums and the lateral, forward and rotation gain multiplies,
// then 16 cordic steps, one per cycle, then 8 partial products on the multiplier
// snapshot, unused and skipped items go from decode straight to the finish state
// the result sits in an output register, so a new item is taken while it waits
// aresetn is synchronous and active low; it restores the default gains and zeroes the pose
`default_nettype none

module mecanum_wheel_odometry_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_cmd,
    input  wire logic [31:0]        s_now_us,
    input  wire logic signed [31:0] s_count_front_left,
    input  wire logic signed [31:0] s_count_front_right,
    input  wire logic signed [31:0] s_count_rear_left,
    input  wire logic signed [31:0] s_count_rear_right,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_pose_x,
    output logic signed [31:0]      m_pose_y,
    output logic signed [31:0]      m_pose_heading,
    output logic                    m_applied
);
    import mwo_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DECODE = 8'b0000_0010,
        ST_SUMS   = 8'b0000_0100,
        ST_GAIN   = 8'b0000_1000,
        ST_ANGLE  = 8'b0001_0000,
        ST_ROTATE = 8'b0010_0000,
        ST_PROD   = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } state_t;

    localparam logic signed [ACC_W-1:0] POS_MAX = ACC_W'(48'sh7FFF_FFFF_FFFF);
    localparam logic signed [ACC_W-1:0] POS_MIN = -POS_MAX - ACC_W'(1);

    state_t                     state_reg, state_next;
    logic [3:0]                 step_reg, step_next;
    logic [CI_W-1:0]            iter_reg, iter_next;
    logic [GAIN_W-1:0]          lin_gain_reg, lin_gain_next;
    logic [GAIN_W-1:0]          ang_gain_reg, ang_gain_next;
    logic [31:0]                max_gap_reg, max_gap_next;
    logic [3:0][31:0]           prev_reg, prev_next;
    logic [31:0]                last_time_reg, last_time_next;
    logic signed [POS_W-1:0]    x_acc_reg, x_acc_next;
    logic signed [POS_W-1:0]    y_acc_reg, y_acc_next;
    logic [31:0]                heading_reg, heading_next;
    logic                       applied_reg, applied_next;
    logic                       m_valid_reg, m_valid_next;

    cmd_t                       cmd_reg, cmd_next;
    logic [31:0]                now_reg, now_next;
    logic [3:0][31:0]           cnt_reg, cnt_next;
    logic [3:0][31:0]           delta_reg, delta_next;
    logic signed [SUM_WIDTH-1:0] lat_reg, lat_next;
    logic signed [SUM_WIDTH-1:0] fwd_reg, fwd_next;
    logic signed [SUM_WIDTH-1:0] rot_reg, rot_next;
    logic signed [DV_W-1:0]     dvx_reg, dvx_next;
    logic signed [DV_W-1:0]     dvy_reg, dvy_next;
    logic [31:0]                dw_reg, dw_next;
    logic signed [CW-1:0]       cx_reg, cx_next;
    logic signed [CW-1:0]       cy_reg, cy_next;
    logic signed [CW-1:0]       cz_reg, cz_next;
    logic                       flip_reg, flip_next;
    logic signed [2*MUL_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [31:0]         px_reg, px_next;
    logic signed [31:0]         py_reg, py_next;
    logic signed [31:0]         ph_reg, ph_next;
    logic                       pa_reg, pa_next;

    logic signed [MUL_W-1:0]    ma, mb;
    logic [31:0]                gap;
    logic                       gap_ok;
    logic signed [33:0]         d0, d1, d2, d3;
    logic [31:0]                mid;
    logic signed [CW-1:0]       sh_x, sh_y, at;
    logic signed [31:0]         cs_w, sn_w, coef;
    logic signed [DV_W-1:0]     dv_sel;
    logic [2:0]                 kterm, cterm;
    logic signed [ACC_W-1:0]    term, acc_sum, acc_fin;

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_pose_x       = px_reg;
    assign m_pose_y       = py_reg;
    assign m_pose_heading = ph_reg;
    assign m_applied      = pa_reg;

    // shared operand views
    assign gap    = now_reg - last_time_reg;
    assign gap_ok = (gap != 32'd0) && (gap <= max_gap_reg);
    assign d0     = 34'(signed'(delta_reg[0]));
    assign d1     = 34'(signed'(delta_reg[1]));
    assign d2     = 34'(signed'(delta_reg[2]));
    assign d3     = 34'(signed'(delta_reg[3]));
    assign mid    = heading_reg + {dw_reg[31], dw_reg[31:1]};
    assign sh_x   = cx_reg >>> iter_reg;
    assign sh_y   = cy_reg >>> iter_reg;
    assign at     = signed'({2'b00, atan_lut(5'(iter_reg))});
    assign cs_w   = 32'(flip_reg ? -cx_reg : cx_reg);
    assign sn_w   = 32'(flip_reg ? -cy_reg : cy_reg);
    assign kterm  = step_reg[2:0];
    assign cterm  = 3'(step_reg - 4'd1);
    assign dv_sel = kterm[1] ? dvy_reg : dvx_reg;
    assign coef   = (kterm[2] ^ kterm[1]) ? sn_w : cs_w;
    assign term   = cterm[0] ? ACC_W'(prod_reg >>> 30) : ACC_W'(prod_reg);
    assign acc_sum = (cterm == 3'd2 || cterm == 3'd3) ? acc_reg - term : acc_reg + term;
    assign acc_fin = (acc_sum > POS_MAX) ? POS_MAX : ((acc_sum < POS_MIN) ? POS_MIN : acc_sum);

    // multiplier operand select
    always_comb begin
        ma = '0;
        mb = '0;
        if (state_reg == ST_GAIN) begin
            unique case (step_reg[1:0])
                2'd0: begin
                    ma = MUL_W'(lat_reg);
                    mb = signed'(MUL_W'(lin_gain_reg));
                end
                2'd1: begin
                    ma = MUL_W'(fwd_reg);
                    mb = signed'(MUL_W'(lin_gain_reg));
                end
                2'd2: begin
                    ma = MUL_W'(rot_reg);
                    mb = signed'(MUL_W'(ang_gain_reg));
                end
                default: begin
                    ma = '0;
                    mb = '0;
                end
            endcase
        end else if (state_reg == ST_PROD) begin
            ma = kterm[0] ? signed'(MUL_W'(dv_sel[29:0])) : MUL_W'(signed'(dv_sel[DV_W-1:30]));
            mb = MUL_W'(coef);
        end
    end

    assign prod_next = ma * mb;

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        iter_next      = iter_reg;
        lin_gain_next  = lin_gain_reg;
        ang_gain_next  = ang_gain_reg;
        max_gap_next   = max_gap_reg;
        prev_next      = prev_reg;
        last_time_next = last_time_reg;
        x_acc_next     = x_acc_reg;
        y_acc_next     = y_acc_reg;
        heading_next   = heading_reg;
        applied_next   = applied_reg;
        m_valid_next   = m_valid_reg;
        cmd_next       = cmd_reg;
        now_next       = now_reg;
        cnt_next       = cnt_reg;
        delta_next     = delta_reg;
        lat_next       = lat_reg;
        fwd_next       = fwd_reg;
        rot_next       = rot_reg;
        dvx_next       = dvx_reg;
        dvy_next       = dvy_reg;
        dw_next        = dw_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        flip_next      = flip_reg;
        acc_next       = acc_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        ph_next        = ph_reg;
        pa_next        = pa_reg;

        if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_index))
                REG_LIN_GAIN: lin_gain_next = cfg_wdata[GAIN_W-1:0];
                REG_ANG_GAIN: ang_gain_next = cfg_wdata[GAIN_W-1:0];
                REG_MAX_GAP:  max_gap_next  = cfg_wdata;
                default:      ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next     = cmd_t'(s_cmd);
                    now_next     = s_now_us;
                    cnt_next[0]  = s_count_front_left;
                    cnt_next[1]  = s_count_front_right;
                    cnt_next[2]  = s_count_rear_left;
                    cnt_next[3]  = s_count_rear_right;
                    applied_next = 1'b0;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = ST_FINISH;
                unique case (cmd_reg)
                    CMD_UPDATE: begin
                        last_time_next = now_reg;
                        if (gap_ok) begin
                            for (int j = 0; j < 4; j++) begin
                                delta_next[j] = cnt_reg[j] - prev_reg[j];
                            end
                            prev_next  = cnt_reg;
                            state_next = ST_SUMS;
                        end
                    end
                    CMD_INIT: begin
                        prev_next      = cnt_reg;
                        last_time_next = now_reg;
                    end
                    CMD_ZERO: begin
                        prev_next    = cnt_reg;
                        x_acc_next   = '0;
                        y_acc_next   = '0;
                        heading_next = '0;
                    end
                    default: ;
                endcase
            end
            ST_SUMS: begin
                lat_next   = sat_sum(-d0 + d1 + d2 - d3);
                fwd_next   = sat_sum(d0 + d1 + d2 + d3);
                rot_next   = sat_sum(-d0 + d1 - d2 + d3);
                step_next  = 4'd0;
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                step_next = step_reg + 4'd1;
                unique case (step_reg[1:0])
                    2'd1:    dvx_next = DV_W'(prod_reg);
                    2'd2:    dvy_next = DV_W'(prod_reg);
                    2'd3: begin
                        dw_next    = prod_reg[31:0];
                        state_next = ST_ANGLE;
                    end
                    default: ;
                endcase
            end
            ST_ANGLE: begin
                cx_next   = CORDIC_START;
                cy_next   = '0;
                iter_next = '0;
                // fold angles beyond a quarter turn by half a turn
                if (signed'(mid) > QUARTER || signed'(mid) < -QUARTER) begin
                    cz_next   = CW'(signed'({~mid[31], mid[30:0]}));
                    flip_next = 1'b1;
                end else begin
                    cz_next   = CW'(signed'(mid));
                    flip_next = 1'b0;
                end
                state_next = ST_ROTATE;
            end
            ST_ROTATE: begin
                if (!cz_reg[CW-1]) begin
                    cx_next = cx_reg - sh_y;
                    cy_next = cy_reg + sh_x;
                    cz_next = cz_reg - at;
                end else begin
                    cx_next = cx_reg + sh_y;
                    cy_next = cy_reg - sh_x;
                    cz_next = cz_reg + at;
                end
                iter_next = iter_reg + CI_W'(1);
                if (iter_reg == CI_W'(CORDIC_STEPS - 1)) begin
                    step_next  = 4'd0;
                    state_next = ST_PROD;
                end
            end
            ST_PROD: begin
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd0) begin
                    acc_next = ACC_W'(x_acc_reg);
                end else if (step_reg == 4'd4) begin
                    x_acc_next = POS_W'(acc_fin);
                    acc_next   = ACC_W'(y_acc_reg);
                end else if (step_reg == 4'd8) begin
                    y_acc_next   = POS_W'(acc_fin);
                    heading_next = heading_reg + dw_reg;
                    applied_next = 1'b1;
                    state_next   = ST_FINISH;
                end else begin
                    acc_next = acc_sum;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    px_next      = x_acc_reg[47:16];
                    py_next      = y_acc_reg[47:16];
                    ph_next      = heading_reg;
                    pa_next      = applied_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            iter_reg      <= '0;
            lin_gain_reg  <= LIN_GAIN_RST;
            ang_gain_reg  <= ANG_GAIN_RST;
            max_gap_reg   <= MAX_GAP_RST;
            prev_reg      <= '0;
            last_time_reg <= '0;
            x_acc_reg     <= '0;
            y_acc_reg     <= '0;
            heading_reg   <= '0;
            applied_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            iter_reg      <= iter_next;
            lin_gain_reg  <= lin_gain_next;
            ang_gain_reg  <= ang_gain_next;
            max_gap_reg   <= max_gap_next;
            prev_reg      <= prev_next;
            last_time_reg <= last_time_next;
            x_acc_reg     <= x_acc_next;
            y_acc_reg     <= y_acc_next;
            heading_reg   <= heading_next;
            applied_reg   <= applied_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        now_reg   <= now_next;
        cnt_reg   <= cnt_next;
        delta_reg <= delta_next;
        lat_reg   <= lat_next;
        fwd_reg   <= fwd_next;
        rot_reg   <= rot_next;
        dvx_reg   <= dvx_next;
        dvy_reg   <= dvy_next;
        dw_reg    <= dw_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        flip_reg  <= flip_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        ph_reg    <= ph_next;
        pa_reg    <= pa_next;
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_mecanum_wheel_odometry_top.sv
// testbench for the mecanum odometry block: directed table, then random items checked against a pose predictor
`timescale 1ns / 100ps

module tb_mecanum_wheel_odometry_top;
    import mwo_pkg::*;

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     PHASE_ITEMS    = 250;
    localparam int     NUM_PHASES     = 6;
    localparam longint ACC_HI         = (longint'(1) <<< 47) - 1;
    localparam longint ACC_LO         = -ACC_HI - 1;
    localparam longint QUARTER_BAM    = longint'(1) <<< 30;
    localparam longint UNIT_Q30       = 64'sd652032874;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] heading;
        logic               applied;
    } pose_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] now;
        logic [31:0] fl;
        logic [31:0] fr;
        logic [31:0] rl;
        logic [31:0] rr;
        logic        has_want;
        pose_t       want;
    } odo_item_t;

    localparam pose_t POSE_IDLE    = '{32'sd0, 32'sd0, 32'sd0, 1'b0};
    localparam pose_t POSE_STILL   = '{32'sd0, 32'sd0, 32'sd0, 1'b1};

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    reg_idx_t           cfg_index = REG_NONE;
    logic [31:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    cmd_t               s_cmd = CMD_NONE;
    logic [31:0]        s_now_us = '0;
    logic signed [31:0] s_count_front_left = '0;
    logic signed [31:0] s_count_front_right = '0;
    logic signed [31:0] s_count_rear_left = '0;
    logic signed [31:0] s_count_rear_right = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_pose_x;
    logic signed [31:0] m_pose_y;
    logic signed [31:0] m_pose_heading;
    logic               m_applied;

    // predictor state and register copies
    logic [23:0] gain_lin = 24'd360000;
    logic [23:0] gain_ang = 24'd286000;
    logic [31:0] gap_limit = 32'd500000;
    logic [31:0] prev_fl = '0, prev_fr = '0, prev_rl = '0, prev_rr = '0;
    logic [31:0] stamp_prev = '0;
    longint      pos_x_acc = 0, pos_y_acc = 0;
    logic [31:0] head_bam = '0;

    // stimulus side view of the wheels and clock
    logic [31:0] drive_cnt [4] = '{32'h0, 32'h0, 32'h0, 32'h0};
    logic [31:0] drive_time = '0;

    pose_t pose_q[$];
    int    err_count = 0;
    int    idle_odds = 0;
    int    quiet_cycles = 0;
    int    hold_m = 0;

    logic [31:0] atan_bam [32] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
        32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
        32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
    };

    odo_item_t seq_table [19] = '{
        '{CMD_UPDATE, 32'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, POSE_IDLE},
        '{CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 1'b1, POSE_IDLE},
        '{CMD_INIT, 32'd1000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
          1'b1, POSE_IDLE},
        '{CMD_UPDATE, 32'd1000, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, POSE_IDLE},
        '{CMD_UPDATE, 32'd501001, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, POSE_IDLE},
        '{CMD_UPDATE, 32'd1001001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF,
          1'b1, POSE_STILL},
        '{CMD_UPDATE, 32'd1001002, 32'h8000_03E7, 32'h8000_03E8, 32'h0000_03E8,
          32'h0000_03E7, 1'b0, POSE_IDLE},
        '{CMD_UPDATE, 32'd1001102, 32'h8000_01F3, 32'h8000_05DC, 32'h0000_05DC,
          32'h0000_01F3, 1'b0, POSE_IDLE},
        '{CMD_UPDATE, 32'd1001103, 32'h7FFF_F63B, 32'h8000_1194, 32'hFFFF_FA24,
          32'h0000_0DAB, 1'b0, POSE_IDLE},
        '{CMD_UPDATE, 32'd1001202, 32'hBFFF_F63B, 32'hC000_1194, 32'h3FFF_FA24,
          32'h4000_0DAB, 1'b0, POSE_IDLE},
        '{CMD_UPDATE, 32'd1001302, 32'h3FFF_F63B, 32'h4000_1194, 32'hBFFF_FA24,
          32'hC000_0DAB, 1'b0, POSE_IDLE},
        '{CMD_ZERO, 32'd5, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, POSE_IDLE},
        '{CMD_UPDATE, 32'd1001303, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, POSE_STILL},
        '{CMD_INIT, 32'hFFFF_FF00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, POSE_IDLE},
        '{CMD_UPDATE, 32'h0000_0010, 32'h64, 32'h64, 32'h64, 32'h64, 1'b0, POSE_IDLE},
        '{CMD_UPDATE, 32'h0000_0020, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h7FFF_FFFF, 1'b0, POSE_IDLE},
        '{CMD_NONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, POSE_IDLE},
        '{CMD_UPDATE, 32'h0000_0030, 32'h7FFF_D8F0, 32'h8000_270F, 32'h7FFF_D8F0,
          32'h8000_270F, 1'b0, POSE_IDLE},
        '{CMD_UPDATE, 32'h0007_A151, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, POSE_IDLE}
    };

    mecanum_wheel_odometry_top dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_cmd               (s_cmd),
        .s_now_us            (s_now_us),
        .s_count_front_left  (s_count_front_left),
        .s_count_front_right (s_count_front_right),
        .s_count_rear_left   (s_count_rear_left),
        .s_count_rear_right  (s_count_rear_right),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_pose_x            (m_pose_x),
        .m_pose_y            (m_pose_y),
        .m_pose_heading      (m_pose_heading),
        .m_applied           (m_applied)
    );

    always #10 aclk = ~aclk;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // floor(a * c / 2^30) on a wide product
    function automatic longint scale_q30(input longint a, input longint c);
        logic signed [95:0] p;
        p = a;
        p = p * c;
        return longint'(p >>> 30);
    endfunction

    function automatic void bam_sincos(input logic [31:0] ang, output longint c,
                                       output longint s);
        longint z;
        longint cx;
        longint cy;
        longint t;
        logic   flip;
        z = longint'($signed(ang));
        cx = UNIT_Q30;
        cy = 0;
        flip = 1'b0;
        if (z > QUARTER_BAM || z < -QUARTER_BAM) begin
            z = longint'($signed(ang + 32'h8000_0000));
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            if (z >= 0) begin
                t = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                z = z - longint'(atan_bam[i]);
            end else begin
                t = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                z = z + longint'(atan_bam[i]);
            end
            cx = t;
        end
        c = flip ? -cx : cx;
        s = flip ? -cy : cy;
    endfunction

    // applies one item to the pose state and returns the pose it reports
    function automatic pose_t advance_pose(input odo_item_t it);
        pose_t       r;
        logic [31:0] gap;
        logic [31:0] dw;
        logic [31:0] mid;
        longint      dfl, dfr, drl, drr;
        longint      smax, lat, fwd, rot, dvx, dvy, cs, sn;
        r.applied = 1'b0;
        case (it.cmd)
            CMD_INIT, CMD_ZERO: begin
                prev_fl = it.fl;
                prev_fr = it.fr;
                prev_rl = it.rl;
                prev_rr = it.rr;
                if (it.cmd == CMD_INIT) begin
                    stamp_prev = it.now;
                end else begin
                    pos_x_acc = 0;
                    pos_y_acc = 0;
                    head_bam = '0;
                end
            end
            CMD_UPDATE: begin
                gap = it.now - stamp_prev;
                stamp_prev = it.now;
                if (gap != 0 && gap <= gap_limit) begin
                    dfl = longint'($signed(it.fl - prev_fl));
                    dfr = longint'($signed(it.fr - prev_fr));
                    drl = longint'($signed(it.rl - prev_rl));
                    drr = longint'($signed(it.rr - prev_rr));
                    smax = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
                    lat = clip(-dfl + dfr + drl - drr, -smax - 1, smax);
                    fwd = clip(dfl + dfr + drl + drr, -smax - 1, smax);
                    rot = clip(-dfl + dfr - drl + drr, -smax - 1, smax);
                    dvx = lat * longint'(gain_lin);
                    dvy = fwd * longint'(gain_lin);
                    dw = 32'(rot * longint'(gain_ang));
                    mid = head_bam + {dw[31], dw[31:1]};
                    bam_sincos(mid, cs, sn);
                    pos_x_acc = clip(pos_x_acc + scale_q30(dvx, cs) - scale_q30(dvy, sn),
                                     ACC_LO, ACC_HI);
                    pos_y_acc = clip(pos_y_acc + scale_q30(dvx, sn) + scale_q30(dvy, cs),
                                     ACC_LO, ACC_HI);
                    head_bam = head_bam + dw;
                    prev_fl = it.fl;
                    prev_fr = it.fr;
                    prev_rl = it.rl;
                    prev_rr = it.rr;
                    r.applied = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.x = 32'(pos_x_acc >>> 16);
        r.y = 32'(pos_y_acc >>> 16);
        r.heading = head_bam;
        return r;
    endfunction

    task automatic report_error(input string msg);
        if (err_count < 40) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        err_count++;
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_LIN_GAIN: gain_lin = val[23:0];
            REG_ANG_GAIN: gain_ang = val[23:0];
            REG_MAX_GAP:  gap_limit = val;
            default: begin
            end
        endcase
    endtask

    task automatic send_item(input odo_item_t it);
        pose_t p;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= it.cmd;
        s_now_us <= it.now;
        s_count_front_left <= it.fl;
        s_count_front_right <= it.fr;
        s_count_rear_left <= it.rl;
        s_count_rear_right <= it.rr;
        do @(posedge aclk); while (!s_ready);
        p = advance_pose(it);
        pose_q.push_back(it.has_want ? it.want : p);
    endtask

    // drop valid and wait until every pose has come back
    task automatic settle();
        s_valid <= 1'b0;
        while (pose_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic next_random_item(output odo_item_t it);
        int          pick;
        int          mode;
        logic [31:0] span;
        logic [31:0] step;
        it = '0;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            it.cmd = CMD_UPDATE;
            span = (gap_limit == 0) ? 32'd1 : ((gap_limit > 50000) ? 32'd50000 : gap_limit);
            mode = $urandom_range(0, 99);
            if (mode < 85) begin
                drive_time = drive_time + $urandom_range(1, span);
            end else if (mode >= 92) begin
                drive_time = $urandom;
            end
            mode = $urandom_range(0, 99);
            if (mode < 70) begin
                for (int k = 0; k < 4; k++) begin
                    drive_cnt[k] = drive_cnt[k] + $urandom_range(0, 4000) - 2000;
                end
            end else if (mode < 85) begin
                step = $urandom;
                for (int k = 0; k < 4; k++) begin
                    drive_cnt[k] = drive_cnt[k] + step;
                end
            end else begin
                for (int k = 0; k < 4; k++) begin
                    drive_cnt[k] = $urandom;
                end
            end
        end else if (pick < 91) begin
            it.cmd = (pick < 88) ? CMD_INIT : CMD_ZERO;
            drive_time = drive_time + $urandom_range(0, 1000);
            for (int k = 0; k < 4; k++) begin
                drive_cnt[k] = $urandom;
            end
        end else if (pick < 95) begin
            it.cmd = CMD_NONE;
        end else begin
            // noise update with every field random
            it.cmd = CMD_UPDATE;
            drive_time = $urandom;
            for (int k = 0; k < 4; k++) begin
                drive_cnt[k] = $urandom;
            end
        end
        if (it.cmd == CMD_NONE) begin
            it.now = $urandom;
            it.fl = $urandom;
            it.fr = $urandom;
            it.rl = $urandom;
            it.rr = $urandom;
        end else begin
            it.now = drive_time;
            it.fl = drive_cnt[0];
            it.fr = drive_cnt[1];
            it.rl = drive_cnt[2];
            it.rr = drive_cnt[3];
        end
    endtask

    always @(posedge aclk) begin
        if (hold_m > 0) begin
            m_ready <= 1'b0;
            hold_m <= hold_m - 1;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            m_ready <= 1'b0;
            hold_m <= $urandom_range(0, 14);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        pose_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pose_q.size() == 0) begin
                report_error($sformatf("unexpected pose x %h y %h heading %h applied %b",
                                       m_pose_x, m_pose_y, m_pose_heading, m_applied));
            end else begin
                want = pose_q.pop_front();
                if (m_pose_x !== want.x) begin
                    report_error($sformatf("pose_x got %h want %h", m_pose_x, want.x));
                end
                if (m_pose_y !== want.y) begin
                    report_error($sformatf("pose_y got %h want %h", m_pose_y, want.y));
                end
                if (m_pose_heading !== want.heading) begin
                    report_error($sformatf("pose_heading got %h want %h",
                                           m_pose_heading, want.heading));
                end
                if (m_applied !== want.applied) begin
                    report_error($sformatf("applied got %b want %b", m_applied, want.applied));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        odo_item_t   it;
        int          done_items;
        logic [31:0] lin_word;
        logic [31:0] ang_word;
        logic [31:0] gap_word;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        idle_odds = 4;
        foreach (seq_table[r]) begin
            send_item(seq_table[r]);
        end
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            lin_word = $urandom;
            ang_word = $urandom;
            case (phase)
                0: begin
                    lin_word[23:0] = 24'hFF_FFFF;
                    ang_word[23:0] = 24'hFF_FFFF;
                    gap_word = 32'hFFFF_FFFF;
                end
                1: begin
                    lin_word[23:0] = 24'd0;
                    ang_word[23:0] = 24'd0;
                    gap_word = 32'd0;
                end
                2: begin
                    lin_word[23:0] = 24'd1;
                    ang_word[23:0] = 24'd1;
                    gap_word = 32'd1;
                end
                3: gap_word = $urandom_range(1, 2000000);
                4: gap_word = $urandom;
                default: begin
                    lin_word[23:0] = 24'd360000;
                    ang_word[23:0] = 24'd286000;
                    gap_word = 32'd500000;
                end
            endcase
            write_reg(REG_LIN_GAIN, lin_word);
            write_reg(REG_ANG_GAIN, ang_word);
            write_reg(REG_MAX_GAP, gap_word);
            write_reg(REG_NONE, $urandom);
            done_items = 0;
            while (done_items < PHASE_ITEMS) begin
                if (phase == NUM_PHASES - 1) begin
                    idle_odds = 0;
                end else if (done_items % 50 == 0) begin
                    case ($urandom_range(0, 3))
                        0: idle_odds = 0;
                        1: idle_odds = 2;
                        2: idle_odds = 5;
                        default: idle_odds = 12;
                    endcase
                end
                next_random_item(it);
                send_item(it);
                if (it.cmd != CMD_NONE) begin
                    done_items++;
                end
            end
        end
        s_valid <= 1'b0;
        while (pose_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mwo_pkg.sv
rtl/mecanum_wheel_odometry_top.sv
tb/sv/tb_mecanum_wheel_odometry_top.sv
